### design/hkv_pkg.sv
package hkv_pkg;

    localparam int BUCKET_BITS = 8;
    localparam int WAYS        = 4;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 64;
    localparam int NBUCKETS    = 1 << BUCKET_BITS;
    localparam int SLOT_W      = KEY_W + VAL_W;
    localparam logic [63:0] HASH_MULT = 64'h61C8864680B583EB;
    localparam int QDEPTH      = 2;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_LOOKUP = 2'd2;
    localparam opcode_t OP_UNUSED = 2'd3;

    typedef logic [BUCKET_BITS-1:0] bucket_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        bucket_t           bucket;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [VAL_W-1:0]  old_value;
        logic              status;
    } rsp_t;

endpackage

### design/hkv_if.sv
interface hkv_req_if;
    import hkv_pkg::*;
    logic             valid;
    logic             ready;
    opcode_t          opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface hkv_rsp_if;
    import hkv_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [VAL_W-1:0] old_value;
    logic             status;
    modport source (output valid, hit, old_value, status, input ready);
    modport sink   (input valid, hit, old_value, status, output ready);
endinterface

### design/hkv_front.sv
// Hash stage: registers the word with its partial products, then a two-entry queue.
module hkv_front (
    input  logic          clk,
    input  logic          rst_n,
    hkv_req_if.sink       req,
    output hkv_pkg::req_t q_data,
    output logic          q_valid,
    input  logic          q_ready
);
    import hkv_pkg::*;

    // key * HASH_MULT mod 2^64, upper word = hi(key * M_lo) + lo(key * M_hi)
    logic [63:0]      prod_lo;
    logic [31:0]      prod_hi;
    logic [31:0]      hsum;
    opcode_t          stg_op_reg;
    logic [KEY_W-1:0] stg_key_reg;
    logic [VAL_W-1:0] stg_val_reg;
    logic [31:0]      hlo_reg;
    logic [31:0]      hhi_reg;
    req_t             stg_word;
    logic             stg_valid_reg;
    req_t             q_mem_reg [QDEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign prod_lo = {32'd0, req.key} * {32'd0, HASH_MULT[31:0]};
    assign prod_hi = req.key * HASH_MULT[63:32];
    assign hsum    = hlo_reg + hhi_reg;

    always_comb
    begin
        stg_word.opcode = stg_op_reg;
        stg_word.key    = stg_key_reg;
        stg_word.value  = stg_val_reg;
        stg_word.bucket = hsum[31 -: BUCKET_BITS];
    end

    assign push = stg_valid_reg && (cnt_reg != 2'(QDEPTH));
    assign pop  = q_valid && q_ready;
    assign req.ready = !stg_valid_reg || push;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (req.ready)
                stg_valid_reg <= req.valid;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            stg_op_reg  <= req.opcode;
            stg_key_reg <= req.key;
            stg_val_reg <= req.value;
            hlo_reg     <= prod_lo[63:32];
            hhi_reg     <= prod_hi;
        end
        if (push)
            q_mem_reg[wr_ptr_reg] <= stg_word;
    end

endmodule

### design/hkv_back.sv
// Read bucket, compare ways, write back, then take the next request.
module hkv_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hkv_pkg::req_t q_data,
    input  logic          q_valid,
    output logic          q_ready,
    hkv_rsp_if.source     rsp
);
    import hkv_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    bucket_t                clr_cnt_reg;
    logic [SLOT_W*WAYS-1:0] mem [NBUCKETS];
    logic [SLOT_W*WAYS-1:0] rd_reg;
    logic [WAYS-1:0]        vmem [NBUCKETS];
    logic [WAYS-1:0]        vrd_reg;
    req_t                   cur_reg;
    rsp_t                   out_reg;
    logic                   out_valid_reg;

    logic [WAYS-1:0]        match_oh, free_oh;
    logic                   found, has_free;
    logic [VAL_W-1:0]       old_val;
    logic [SLOT_W*WAYS-1:0] wr_row;
    logic                   do_write;
    logic [WAYS-1:0]        vbits_new;
    rsp_t                   rsp_next;
    logic                   seen_m, seen_f;

    assign q_ready = (state_reg == ST_READ) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        seen_m = 1'b0;
        seen_f = 1'b0;
        match_oh = '0;
        free_oh  = '0;
        old_val  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (vrd_reg[w])
            begin
                if (!seen_m && rd_reg[w*SLOT_W+VAL_W +: KEY_W] == cur_reg.key)
                begin
                    seen_m = 1'b1;
                    match_oh[w] = 1'b1;
                    old_val = rd_reg[w*SLOT_W +: VAL_W];
                end
            end
            else if (!seen_f)
            begin
                seen_f = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
        found    = seen_m;
        has_free = seen_f;
        wr_row   = rd_reg;
        vbits_new = vrd_reg;
        do_write = 1'b0;
        rsp_next.hit = 1'b0;
        rsp_next.old_value = '0;
        rsp_next.status = 1'b0;
        if (cur_reg.opcode != OP_UNUSED && found)
        begin
            rsp_next.hit = 1'b1;
            rsp_next.old_value = old_val;
        end
        case (cur_reg.opcode)
            OP_INSERT:
            begin
                do_write = found || has_free;
                rsp_next.status = !do_write;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (match_oh[w] || (!found && free_oh[w]))
                    begin
                        wr_row[w*SLOT_W +: SLOT_W] = {cur_reg.key, cur_reg.value};
                        vbits_new[w] = 1'b1;
                    end
                end
            end
            OP_REMOVE:
                vbits_new = vrd_reg & ~match_oh;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                        state_reg <= ST_READ;
                end
                ST_READ:
                    if (q_valid && q_ready)
                        state_reg <= ST_EXEC;
                ST_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_READ;
                end
                default:
                    state_reg <= ST_READ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cur_reg <= q_data;
            rd_reg  <= mem[q_data.bucket];
            vrd_reg <= vmem[q_data.bucket];
        end
        // valid bits are wiped one bucket per cycle after reset
        if (state_reg == ST_CLEAR)
            vmem[clr_cnt_reg] <= '0;
        else if (state_reg == ST_EXEC)
            vmem[cur_reg.bucket] <= vbits_new;
        if (state_reg == ST_EXEC)
        begin
            out_reg <= rsp_next;
            if (do_write)
                mem[cur_reg.bucket] <= wr_row;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_reg.hit;
    assign rsp.old_value = out_reg.old_value;
    assign rsp.status    = out_reg.status;

endmodule

### design/hashed_key_value_table.sv
// A request accepted passes the hash stage registers and the two-entry queue; the
// back end then reads the bucket row, compares ways, writes back and registers the
// response. It takes no new request until that read-modify-write is done.
// After reset the back end clears the slot valid bits one bucket per cycle, all
// 256 buckets, before it takes requests; keys and values are not reset.
module hashed_key_value_table (
    input logic       clk,
    input logic       rst_n,
    hkv_req_if.sink   req,
    hkv_rsp_if.source rsp
);
    import hkv_pkg::*;

    req_t q_data;
    logic q_valid, q_ready;

    hkv_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
    );

    hkv_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready), .rsp(rsp)
    );

endmodule

### design/hkv_checker.sv
module hkv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       hit,
    input logic [63:0] old_value,
    input logic       status
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(old_value))
        else $error("response dropped while stalled");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> old_value == 64'd0)
        else $error("miss with nonzero value");
    a_status_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !hit)
        else $error("dropped insert reports hit");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response right after reset");
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> !$isunknown(req_ready))
        else $error("request ready unknown");
endmodule

bind hashed_key_value_table hkv_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .hit(rsp.hit), .old_value(rsp.old_value), .status(rsp.status)
);

### tb/tb_hashed_key_value_table.sv
`timescale 1ns / 100ps

module tb_hashed_key_value_table;
    import hkv_pkg::*;

    typedef struct {
        opcode_t            opcode;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } kv_req_t;

    typedef struct {
        logic               hit;
        logic [VAL_W-1:0]   old_value;
        logic               status;
    } kv_rsp_t;

    localparam int NSLOTS    = NBUCKETS * WAYS;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;

    hkv_req_if req ();
    hkv_rsp_if rsp ();

    hashed_key_value_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor copy of the table
    logic               tbl_valid [NSLOTS];
    logic [KEY_W-1:0]   tbl_key   [NSLOTS];
    logic [VAL_W-1:0]   tbl_value [NSLOTS];

    kv_req_t pending_words[$];
    kv_rsp_t expected_rsp[$];
    logic [KEY_W-1:0] key_pool[$];

    int  errors = 0;
    int  cycle = 0;
    bit  no_idle;
    int  hold_off;
    bit  want_hold;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bucket_t bucket_of(logic [KEY_W-1:0] k);
        logic [63:0] prod;
        prod = {32'd0, k} * HASH_MULT;
        return prod[63 -: BUCKET_BITS];
    endfunction

    function automatic kv_rsp_t apply_to_table(kv_req_t r);
        kv_rsp_t res;
        int      base;
        int      match;
        int      free_slot;
        base      = int'(bucket_of(r.key)) * WAYS;
        match     = -1;
        free_slot = -1;
        res.hit       = 1'b0;
        res.old_value = '0;
        res.status    = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (tbl_valid[base + w])
            begin
                if (match < 0 && tbl_key[base + w] == r.key)
                    match = base + w;
            end
            else if (free_slot < 0)
                free_slot = base + w;
        end
        if (r.opcode inside {OP_INSERT, OP_REMOVE, OP_LOOKUP} && match >= 0)
        begin
            res.hit       = 1'b1;
            res.old_value = tbl_value[match];
        end
        if (r.opcode == OP_INSERT)
        begin
            if (match >= 0)
                tbl_value[match] = r.value;
            else if (free_slot >= 0)
            begin
                tbl_valid[free_slot] = 1'b1;
                tbl_key[free_slot]   = r.key;
                tbl_value[free_slot] = r.value;
            end
            else
                res.status = 1'b1;
        end
        else if (r.opcode == OP_REMOVE && match >= 0)
            tbl_valid[match] = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] exp);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, exp);
        errors++;
    endtask

    task automatic push_word(opcode_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        kv_req_t r;
        r.opcode = op;
        r.key    = k;
        r.value  = v;
        pending_words.push_back(r);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // keys that share one bucket, to fill it past WAYS
    function automatic void collect_same_bucket(bucket_t b, int n);
        logic [KEY_W-1:0] k;
        k = $urandom;
        while (n > 0)
        begin
            if (bucket_of(k) == b)
            begin
                key_pool.push_back(k);
                n--;
            end
            k++;
        end
    endfunction

    // driver: the word on the bus stays at the head of the queue until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            req.opcode <= OP_INSERT;
            req.key    <= '0;
            req.value  <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_rsp.push_back(apply_to_table(pending_words.pop_front()));
            end
            if (pending_words.size() > 0)
            begin
                kv_req_t nxt;
                nxt = pending_words[0];
                if (req.valid && !req.ready)
                    req.valid <= 1'b1;
                else if (!no_idle && $urandom_range(99) < 31)
                    req.valid <= 1'b0;
                else
                    req.valid <= 1'b1;
                if (!(req.valid && !req.ready))
                begin
                    req.opcode <= nxt.opcode;
                    req.key    <= nxt.key;
                    req.value  <= nxt.value;
                end
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver stall control, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_off  <= 0;
        end
        else if (want_hold && hold_off == 0)
        begin
            hold_off  <= 300;
            rsp.ready <= 1'b0;
        end
        else if (hold_off > 1)
        begin
            hold_off  <= hold_off - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            hold_off  <= 0;
            rsp.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 31);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("unexpected result word at cycle %0d", cycle);
                errors++;
            end
            else
            begin
                kv_rsp_t e;
                e = expected_rsp.pop_front();
                if (rsp.hit !== e.hit)
                    report_mismatch("hit", VAL_W'(rsp.hit), VAL_W'(e.hit));
                if (rsp.old_value !== e.old_value)
                    report_mismatch("old_value", rsp.old_value, e.old_value);
                if (rsp.status !== e.status)
                    report_mismatch("status", VAL_W'(rsp.status), VAL_W'(e.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("timeout at cycle %0d", cycle);
            $display("tb_hashed_key_value_table: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_rsp.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [KEY_W-1:0] k;
        bucket_t          b;
        opcode_t          op;
        int               sel;
        no_idle   = 0;
        want_hold = 0;
        rst_n     = 1'b0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every op, misses, replace, zero value, full bucket, unused opcode
        push_word(OP_LOOKUP, 32'h0, '0);
        push_word(OP_REMOVE, 32'hFFFF_FFFF, '0);
        push_word(OP_INSERT, 32'h0, '0);
        push_word(OP_LOOKUP, 32'h0, '1);
        push_word(OP_INSERT, 32'hFFFF_FFFF, '1);
        push_word(OP_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
        push_word(OP_LOOKUP, 32'hFFFF_FFFF, '0);
        push_word(OP_REMOVE, 32'hFFFF_FFFF, '0);
        push_word(OP_LOOKUP, 32'hFFFF_FFFF, '0);
        push_word(OP_UNUSED, 32'h0, '1);
        b = 8'h5A;
        collect_same_bucket(b, WAYS + 1);
        for (int i = 0; i <= WAYS; i++)
            push_word(OP_INSERT, key_pool[i], rand_value());
        push_word(OP_REMOVE, key_pool[1], '0);
        push_word(OP_INSERT, key_pool[WAYS], rand_value());
        push_word(OP_LOOKUP, key_pool[WAYS], '0);
        push_word(OP_INSERT, key_pool[1], rand_value());
        wait_drained();

        // random: keys from a small pool with crowded buckets so hits and full buckets occur
        collect_same_bucket(8'h00, 6);
        collect_same_bucket(8'hFF, 6);
        for (int i = 0; i < 30; i++)
            key_pool.push_back($urandom);
        for (int n = 0; n < 930; n++)
        begin
            if (n == 200)
                no_idle = 1;
            if (n == 350)
                no_idle = 0;
            if (n == 450)
                want_hold = 1;
            if (n == 460)
                want_hold = 0;
            if (n == 600)
                wait_drained();
            sel = $urandom_range(99);
            if (sel < 40)
                op = OP_INSERT;
            else if (sel < 65)
                op = OP_REMOVE;
            else if (sel < 97)
                op = OP_LOOKUP;
            else
                op = OP_UNUSED;
            if ($urandom_range(9) < 8)
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                k = $urandom;
            push_word(op, k, rand_value());
            while (pending_words.size() > 8)
                @(posedge clk);
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_hashed_key_value_table: PASS");
        else
            $display("tb_hashed_key_value_table: FAIL");
        $finish;
    end

endmodule
